FILE: sv/tsp_pkg.sv
package tsp_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_SEPARATORS = 2'd1,
        ST_BAD_CHAR   = 2'd2
    } status_t;

    // Characters that carry meaning in a time string.
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Field numbering: 1 hours, 2 minutes, 3 seconds, 4 fraction.
    localparam int          NUM_FIELDS    = 4;
    localparam logic [2:0]  FIELD_FIRST   = 3'd1;
    localparam logic [2:0]  FIELD_COLON_LIMIT = 3'd4;
    localparam logic [2:0]  FIELD_DOT_LIMIT   = 3'd5;

    // Fraction digit count saturates here; nine places make nanoseconds.
    localparam logic [3:0]  FRAC_SAT      = 4'd10;
    localparam logic [3:0]  NANO_PLACES   = 4'd9;

    // A finished string waiting for its fraction to be scaled.
    typedef struct packed {
        logic        negative;
        logic [31:0] hours;
        logic [31:0] minutes;
        logic [31:0] seconds;
        logic [31:0] frac;
        logic [3:0]  scale_exp;
        status_t     status;
    } snap_t;

    // Powers of ten used to scale the fraction, modulo 2^32.
    function automatic logic [31:0] pow10(input logic [3:0] e);
        logic [31:0] r;
        case (e)
            4'd0:    r = 32'd1;
            4'd1:    r = 32'd10;
            4'd2:    r = 32'd100;
            4'd3:    r = 32'd1000;
            4'd4:    r = 32'd10000;
            4'd5:    r = 32'd100000;
            4'd6:    r = 32'd1000000;
            4'd7:    r = 32'd10000000;
            4'd8:    r = 32'd100000000;
            4'd9:    r = 32'd1000000000;
            default: r = 32'd1;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/tsp_parse.sv
module tsp_parse (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     char_code,
    input  logic           is_last,
    input  logic           in_valid,
    output logic           in_stall,
    output tsp_pkg::snap_t snap,
    output logic           snap_valid,
    input  logic           snap_take
);
    import tsp_pkg::*;

    logic [7:0]  char_reg;
    logic        last_reg;
    logic        in_valid_reg;
    logic        in_valid_next;

    logic        at_start_reg,  at_start_next;
    logic        sign_reg,      sign_next;
    logic [2:0]  field_reg,     field_next;
    logic [31:0] accum_reg  [NUM_FIELDS];
    logic [31:0] accum_next [NUM_FIELDS];
    logic        dot_reg,       dot_next;
    logic [3:0]  fdig_reg,      fdig_next;
    status_t     err_reg,       err_next;

    snap_t       snap_reg, snap_next;
    logic        snap_valid_reg, snap_valid_next;

    logic        consume;
    logic        accept;
    logic        is_digit;
    logic        do_digit;
    logic        do_count;
    logic [2:0]  field_inc;
    logic [1:0]  lane_sel;
    logic [31:0] digit_val;

    // The input word moves on unless it is a last character with the
    // result slot still occupied.
    assign consume       = in_valid_reg && (!last_reg || !snap_valid_reg || snap_take);
    assign in_stall      = in_valid_reg && !consume;
    assign accept        = in_valid && !in_stall;
    assign in_valid_next = accept || (in_valid_reg && !consume);
    assign snap_valid_next = (snap_valid_reg && !snap_take) || (consume && last_reg);

    assign field_inc = field_reg + 3'd1;
    assign lane_sel  = 2'(field_reg - 3'd1);
    assign digit_val = {24'd0, char_reg - CH_ZERO};

    always_comb
    begin
        at_start_next = at_start_reg;
        sign_next     = sign_reg;
        field_next    = field_reg;
        dot_next      = dot_reg;
        fdig_next     = fdig_reg;
        err_next      = err_reg;
        is_digit      = char_reg inside {[CH_ZERO:CH_NINE]};
        do_digit      = 1'b0;
        do_count      = 1'b0;
        for (int i = 0; i < NUM_FIELDS; i++)
        begin
            accum_next[i] = accum_reg[i];
        end

        if (consume)
        begin
            at_start_next = 1'b0;
            if (err_reg == ST_OK)
            begin
                if (at_start_reg && char_reg == CH_MINUS)
                begin
                    sign_next = 1'b1;
                end
                else if (char_reg == CH_COLON)
                begin
                    field_next = field_inc;
                    if (field_inc >= FIELD_COLON_LIMIT)
                        err_next = ST_SEPARATORS;
                    else
                        do_count = 1'b1;
                end
                else if (char_reg == CH_DOT)
                begin
                    field_next = field_inc;
                    if (field_inc >= FIELD_DOT_LIMIT)
                    begin
                        err_next = ST_SEPARATORS;
                    end
                    else
                    begin
                        dot_next  = 1'b1;
                        fdig_next = 4'd0;
                    end
                end
                else if (is_digit)
                begin
                    do_digit = 1'b1;
                    do_count = 1'b1;
                end
                else
                begin
                    err_next = ST_BAD_CHAR;
                end
            end

            if (do_count && dot_reg && fdig_reg < FRAC_SAT)
                fdig_next = fdig_reg + 4'd1;

            // Each field has its own multiply-by-ten; only the active one loads.
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                if (do_digit && lane_sel == 2'(i))
                    accum_next[i] = (accum_reg[i] << 3) + (accum_reg[i] << 1) + digit_val;
            end
        end

        // Result snapshot, built from the state after this character.
        snap_next = snap_reg;
        if (err_next != ST_OK)
        begin
            snap_next = '0;
            snap_next.status = err_next;
        end
        else
        begin
            snap_next.negative  = sign_next;
            snap_next.hours     = accum_next[0];
            snap_next.minutes   = accum_next[1];
            snap_next.seconds   = accum_next[2];
            snap_next.frac      = accum_next[3];
            snap_next.scale_exp = (dot_next && fdig_next < NANO_PLACES)
                                  ? (NANO_PLACES - fdig_next) : 4'd0;
            snap_next.status    = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            snap_valid_reg <= 1'b0;
            at_start_reg   <= 1'b1;
            sign_reg       <= 1'b0;
            field_reg      <= FIELD_FIRST;
            dot_reg        <= 1'b0;
            fdig_reg       <= 4'd0;
            err_reg        <= ST_OK;
            for (int i = 0; i < NUM_FIELDS; i++)
            begin
                accum_reg[i] <= 32'd0;
            end
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            snap_valid_reg <= snap_valid_next;
            if (consume && last_reg)
            begin
                // String done: start clean for the next one.
                at_start_reg <= 1'b1;
                sign_reg     <= 1'b0;
                field_reg    <= FIELD_FIRST;
                dot_reg      <= 1'b0;
                fdig_reg     <= 4'd0;
                err_reg      <= ST_OK;
                for (int i = 0; i < NUM_FIELDS; i++)
                begin
                    accum_reg[i] <= 32'd0;
                end
            end
            else
            begin
                at_start_reg <= at_start_next;
                sign_reg     <= sign_next;
                field_reg    <= field_next;
                dot_reg      <= dot_next;
                fdig_reg     <= fdig_next;
                err_reg      <= err_next;
                for (int i = 0; i < NUM_FIELDS; i++)
                begin
                    accum_reg[i] <= accum_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= char_code;
            last_reg <= is_last;
        end
        if (consume && last_reg)
            snap_reg <= snap_next;
    end

    assign snap       = snap_reg;
    assign snap_valid = snap_valid_reg;

endmodule

FILE: sv/tsp_scale.sv
module tsp_scale (
    input  logic           clk,
    input  logic           rst_n,
    input  tsp_pkg::snap_t snap,
    input  logic           snap_valid,
    output logic           snap_take,
    output logic           out_valid,
    input  logic           out_stall,
    output logic           negative,
    output logic [31:0]    hours,
    output logic [31:0]    minutes,
    output logic [31:0]    seconds,
    output logic [31:0]    nanos,
    output logic [1:0]     status
);
    import tsp_pkg::*;

    logic        out_valid_reg;
    logic        load;
    logic [31:0] nanos_scaled;
    logic        negative_reg;
    logic [31:0] hours_reg, minutes_reg, seconds_reg, nanos_reg;
    logic [1:0]  status_reg;

    // The output register refills whenever it is empty or being taken.
    assign load         = !out_valid_reg || !out_stall;
    assign snap_take    = load;
    // Only the low 32 bits of the product are kept, so a 32 by 32 multiply serves.
    assign nanos_scaled = snap.frac * pow10(snap.scale_exp);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= snap_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load && snap_valid)
        begin
            negative_reg <= snap.negative;
            hours_reg    <= snap.hours;
            minutes_reg  <= snap.minutes;
            seconds_reg  <= snap.seconds;
            nanos_reg    <= nanos_scaled;
            status_reg   <= 2'(snap.status);
        end
    end

    assign out_valid = out_valid_reg;
    assign negative  = negative_reg;
    assign hours     = hours_reg;
    assign minutes   = minutes_reg;
    assign seconds   = seconds_reg;
    assign nanos     = nanos_reg;
    assign status    = status_reg;

endmodule

FILE: sv/time_string_parser.sv
// Time string parser. A string of the form [-]H:M:S[.fraction] arrives one
// character per word on the input channel (char_code, is_last, in_valid,
// in_stall); is_last marks the final character of each string. One result
// word leaves on the output channel (negative, hours, minutes, seconds,
// nanos, status, out_valid, out_stall) for each string, after its last
// character.
// Every input word first lands in an input register. The parse stage
// updates the field accumulators with a multiply-by-ten and add, and on the
// last character it captures a snapshot and clears its state, so the next
// string may start in the very next cycle. The scale stage multiplies the
// fraction by a power of ten from a table and fills the output register.
// One character is taken every cycle while in_stall is low. A result goes
// from the input register via the snapshot register to the output register.
// Reset empties all stages and returns the parser to the start of a string.
// When the receiver stalls, the output word holds; the snapshot register
// and then the input register still take words, and in_stall rises only
// when a last character sits in the input register while the snapshot and
// the output word are both held.
// A status other than zero reports a bad separator or character, and the
// other result fields are then zero.
module time_string_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  char_code,
    input  logic        is_last,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        negative,
    output logic [31:0] hours,
    output logic [31:0] minutes,
    output logic [31:0] seconds,
    output logic [31:0] nanos,
    output logic [1:0]  status
);
    import tsp_pkg::*;

    snap_t snap;
    logic  snap_valid;
    logic  snap_take;

    tsp_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_code  (char_code),
        .is_last    (is_last),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .snap       (snap),
        .snap_valid (snap_valid),
        .snap_take  (snap_take)
    );

    tsp_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap       (snap),
        .snap_valid (snap_valid),
        .snap_take  (snap_take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .negative   (negative),
        .hours      (hours),
        .minutes    (minutes),
        .seconds    (seconds),
        .nanos      (nanos),
        .status     (status)
    );

endmodule
